// ----- hw/rtl/sfc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfc_pkg
// shared types, codes and sizes of the sync frame checker
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

    localparam int HEADER_BYTES   = 16;
    localparam int BYTES_PER_WORD = 4;
    localparam int HDR_WORDS      = HEADER_BYTES / BYTES_PER_WORD;
    localparam int FILL_W         = $clog2(HEADER_BYTES + 1);

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

    localparam logic [1:0] CFG_SYNC_BYTE      = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_ENABLE = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd2;

    typedef struct packed {
        logic [7:0]  transport;
        logic [15:0] words;
        logic [31:0] source_high;
        logic [31:0] source_low;
        logic [15:0] payload_sum;
    } hdr_fields_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } win_ctl_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  transport;
        logic [15:0] payload_words;
        logic [16:0] message_words;
        logic [31:0] source_high;
        logic [31:0] source_low;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sfc_header_window.sv -----
// ----------------------------------------------------------------------------
// sfc_header_window
// sliding 16-byte header window with fill count and header checksum test
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_header_window (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sfc_pkg::win_ctl_t ctl,
    input  wire logic [7:0]        data_byte,
    input  wire logic [7:0]        sync_byte,
    output logic                   hdr_good,
    output sfc_pkg::hdr_fields_t   hdr
);

    logic [7:0]                 win_reg  [sfc_pkg::HEADER_BYTES];
    logic [7:0]                 win_next [sfc_pkg::HEADER_BYTES];
    logic [sfc_pkg::FILL_W-1:0] fill_reg;
    logic [sfc_pkg::FILL_W-1:0] fill_next;
    logic                       full_next;
    logic [8:0]                 pair_sum [7];
    logic [10:0]                quad_lo;
    logic [10:0]                quad_hi;
    logic [11:0]                byte_sum;
    logic [15:0]                sum_cpl;
    logic [15:0]                sum_got;

    // window as it stands after this byte
    always_comb begin
        for (int i = 0; i < sfc_pkg::HEADER_BYTES - 1; i++) begin
            win_next[i] = win_reg[i+1];
        end
        win_next[sfc_pkg::HEADER_BYTES-1] = data_byte;
    end

    // adder tree over bytes 0..13
    always_comb begin
        for (int i = 0; i < 7; i++) begin
            pair_sum[i] = {1'b0, win_next[2*i]} + {1'b0, win_next[2*i+1]};
        end
        quad_lo  = {2'b00, pair_sum[0]} + {2'b00, pair_sum[1]}
                 + {2'b00, pair_sum[2]} + {2'b00, pair_sum[3]};
        quad_hi  = {2'b00, pair_sum[4]} + {2'b00, pair_sum[5]} + {2'b00, pair_sum[6]};
        byte_sum = {1'b0, quad_lo} + {1'b0, quad_hi};
        sum_cpl  = ~{4'b0000, byte_sum};
        sum_got  = {win_next[14], win_next[15]};
    end

    assign full_next = (fill_reg >= sfc_pkg::FILL_W'(sfc_pkg::HEADER_BYTES - 1));
    assign hdr_good  = full_next && (win_next[0] == sync_byte) && (sum_cpl == sum_got);

    assign hdr.transport   = win_next[1];
    assign hdr.words       = {win_next[2], win_next[3]};
    assign hdr.source_high = {win_next[4], win_next[5], win_next[6], win_next[7]};
    assign hdr.source_low  = {win_next[8], win_next[9], win_next[10], win_next[11]};
    assign hdr.payload_sum = {win_next[12], win_next[13]};

    always_comb begin
        fill_next = fill_reg;
        if (ctl.clear) begin
            fill_next = '0;
        end else if (ctl.shift && !(fill_reg == sfc_pkg::FILL_W'(sfc_pkg::HEADER_BYTES))) begin
            fill_next = fill_reg + sfc_pkg::FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            win_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sfc_frame_tracker.sv -----
// ----------------------------------------------------------------------------
// sfc_frame_tracker
// frame state: held header, payload byte count and sum, tick timeout, results
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_frame_tracker (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 fire,
    input  wire logic                 kind,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 hdr_good,
    input  wire sfc_pkg::hdr_fields_t win_hdr,
    input  wire logic                 timeout_enable,
    input  wire logic [31:0]          timeout_ticks,
    output sfc_pkg::win_ctl_t         win_ctl,
    output logic                      res_valid,
    output sfc_pkg::result_t          res
);

    logic                 in_payload_reg;
    logic                 in_payload_next;
    logic [17:0]          bytes_left_reg;
    logic [17:0]          bytes_left_next;
    logic [15:0]          psum_reg;
    logic [15:0]          psum_next;
    logic [31:0]          elapsed_reg;
    logic [31:0]          elapsed_next;
    sfc_pkg::hdr_fields_t held_reg;
    logic                 held_load;
    logic                 use_win;
    logic                 hunt;
    sfc_pkg::hdr_fields_t src;

    always_comb begin
        in_payload_next = in_payload_reg;
        bytes_left_next = bytes_left_reg;
        psum_next       = psum_reg;
        elapsed_next    = elapsed_reg;
        held_load       = 1'b0;
        use_win         = 1'b0;
        hunt            = 1'b0;
        win_ctl.shift   = 1'b0;
        res_valid       = 1'b0;
        res.status      = sfc_pkg::STATUS_GOOD;
        if (fire) begin
            if (kind == sfc_pkg::KIND_TICK) begin
                if (in_payload_reg) begin
                    if (elapsed_reg != 32'hffff_ffff) begin
                        elapsed_next = elapsed_reg + 32'd1;
                    end
                    if (timeout_enable && (elapsed_next > timeout_ticks)) begin
                        res_valid  = 1'b1;
                        res.status = sfc_pkg::STATUS_TIMEOUT;
                        hunt       = 1'b1;
                    end
                end
            end else if (in_payload_reg) begin
                psum_next = psum_reg + {8'd0, data_byte};
                if (bytes_left_reg != 18'd0) begin
                    bytes_left_next = bytes_left_reg - 18'd1;
                end
                if (bytes_left_next == 18'd0) begin
                    res_valid  = 1'b1;
                    res.status = (~psum_next == held_reg.payload_sum) ?
                                 sfc_pkg::STATUS_GOOD : sfc_pkg::STATUS_MISMATCH;
                    hunt       = 1'b1;
                end
            end else begin
                win_ctl.shift = 1'b1;
                if (hdr_good) begin
                    held_load = 1'b1;
                    if (win_hdr.words == 16'd0) begin
                        res_valid  = 1'b1;
                        res.status = sfc_pkg::STATUS_GOOD;
                        use_win    = 1'b1;
                        hunt       = 1'b1;
                    end else begin
                        in_payload_next = 1'b1;
                        bytes_left_next = {win_hdr.words, 2'b00};
                        psum_next       = '0;
                        elapsed_next    = '0;
                    end
                end
            end
        end
        if (hunt) begin
            in_payload_next = 1'b0;
            bytes_left_next = '0;
        end
        win_ctl.clear = hunt;

        src               = use_win ? win_hdr : held_reg;
        res.transport     = src.transport;
        res.payload_words = src.words;
        res.message_words = {1'b0, src.words} + 17'(sfc_pkg::HDR_WORDS);
        res.source_high   = src.source_high;
        res.source_low    = src.source_low;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg <= 1'b0;
            bytes_left_reg <= '0;
            psum_reg       <= '0;
            elapsed_reg    <= '0;
        end else begin
            in_payload_reg <= in_payload_next;
            bytes_left_reg <= bytes_left_next;
            psum_reg       <= psum_next;
            elapsed_reg    <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (held_load) begin
            held_reg <= win_hdr;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sync_frame_checker.sv -----
// ----------------------------------------------------------------------------
// sync_frame_checker
// hunts for sync-framed headers in a byte stream and checks each frame
// ----------------------------------------------------------------------------
// The s_ channel carries one request per item: s_tuser is the kind (received
// byte or timer tick), s_tdata the byte. The m_ channel carries one request per
// finished frame: m_tuser is the status (good, payload mismatch, timeout),
// m_tdata the header fields of that frame.
// An accepted request lands in an input register; when fire is high, the window,
// checksum tree and frame counters process it and any result is written to
// the output register, which drives m_tvalid. One request is taken per cycle
// while the output is not stalled; the path from the input register through
// the header adder tree to the output register is combinational.
// When m_tready is low with a result waiting, one more request is still held
// in the input register; s_tready drops only when both are full.
// Reset (aresetn low, synchronous) empties both registers, clears the window
// fill and frame state and loads the register defaults (timeout 1000 ticks,
// disabled, sync byte zero). Register writes on cfg_we take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_frame_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte[7:0]
    input  wire logic [0:0]   s_tuser,   // kind[0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,   // transport[7:0], payload_words[23:8],
                                         // message_words[40:24], source_high[72:41],
                                         // source_low[104:73], zero pad
    output logic [1:0]        m_tuser,   // status[1:0]
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata
);

    logic                 in_valid_reg;
    logic                 in_kind_reg;
    logic [7:0]           in_byte_reg;
    logic                 fire;
    logic                 out_valid_reg;
    sfc_pkg::result_t     out_reg;
    logic [7:0]           sync_byte_reg;
    logic                 timeout_enable_reg;
    logic [31:0]          timeout_ticks_reg;
    sfc_pkg::win_ctl_t    win_ctl;
    logic                 hdr_good;
    sfc_pkg::hdr_fields_t win_hdr;
    logic                 res_valid;
    sfc_pkg::result_t     res;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
    end

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg      <= 8'd0;
            timeout_enable_reg <= 1'b0;
            timeout_ticks_reg  <= 32'd1000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sfc_pkg::CFG_SYNC_BYTE:      sync_byte_reg      <= cfg_wdata[7:0];
                sfc_pkg::CFG_TIMEOUT_ENABLE: timeout_enable_reg <= cfg_wdata[0];
                sfc_pkg::CFG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    sfc_header_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (win_ctl),
        .data_byte (in_byte_reg),
        .sync_byte (sync_byte_reg),
        .hdr_good  (hdr_good),
        .hdr       (win_hdr)
    );

    sfc_frame_tracker u_tracker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (fire),
        .kind           (in_kind_reg),
        .data_byte      (in_byte_reg),
        .hdr_good       (hdr_good),
        .win_hdr        (win_hdr),
        .timeout_enable (timeout_enable_reg),
        .timeout_ticks  (timeout_ticks_reg),
        .win_ctl        (win_ctl),
        .res_valid      (res_valid),
        .res            (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'd0, out_reg.source_low, out_reg.source_high,
                       out_reg.message_words, out_reg.payload_words, out_reg.transport};

`ifndef SYNTHESIS
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("result status out of range");

    a_message_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[40:24] == ({1'b0, m_tdata[23:8]} + 17'd4)))
        else $error("message length does not follow payload length");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled request lost from input register");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");
`endif

endmodule

`default_nettype wire
